// ===== design/rpgbs_pkg.sv =====
// Shared types and constants for the record parse group-by-sum block.
`timescale 1ns / 1ps
`default_nettype none

package rpgbs_pkg;

   // operation codes of an input item
   localparam logic OP_BYTE   = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   // stream characters
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_COLON  = 8'h3A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // bytes skipped blindly after the opening brace
   localparam logic [3:0] HEAD_SKIP = 4'd9;

   // result field widths
   localparam int KEY_W     = 10;
   localparam int KEY_SUM_W = 32;
   localparam int SHARE_W   = 17;
   localparam int SHARE_FRAC = 16;
   localparam logic [SHARE_W-1:0] SHARE_WHOLE = 17'h10000;

   // command queue depth between parser and table engine
   localparam int CMD_DEPTH = 4;

   typedef struct packed {
      logic       operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic                 found;
      logic [KEY_W-1:0]     key;
      logic [KEY_SUM_W-1:0] key_sum;
      logic [SHARE_W-1:0]   share;
   } rsp_type;

endpackage

`default_nettype wire

// ===== design/record_parse_group_by_sum_top.sv =====
// Top level of the record parse group-by-sum block.
`timescale 1ns / 1ps
`default_nettype none

// Usage:
//  req channel (valid/ready): each item is either one byte of a record stream
//  {"key": "x<digits>", "value": <digits>} or a report request. Bytes are taken
//  one per cycle by the parser while req_ready is high; a finished record or
//  a report becomes a command in a 4-entry queue that feeds the table engine.
//  rsp channel (valid/ready): one item per report: found, key, key_sum and the
//  Q1.16 share of the grand total. Data bytes give no result.
//  Throughput: one data byte per cycle while the queue has room. The table
//  engine handles a committed record as a memory read, then a write back.
//  A report scans the table from the cursor at one slot read per cycle, then
//  runs the bit-serial share divider; end-of-table answers skip the divider.
//  The result lands in an output register.
//  Reset: a clearing pass writes zero to every table slot with req_ready low;
//  the parser, cursor and grand total reset at once.
//  Receiver stall: a pending result holds the register; data bytes and record
//  commits keep flowing until the next report reaches the head of the queue.
//  That report then waits with every command behind it, and once the queue
//  is full req_ready drops.
module record_parse_group_by_sum_top #(
   parameter int KEY_SLOTS = 1024,
   parameter int SUM_BITS  = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rpgbs_pkg::req_type  req_data,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rpgbs_pkg::rsp_type       rsp_data
);

   localparam int KEY_BITS = $clog2(KEY_SLOTS);
   // command: {is_report, key, value}
   localparam int CMD_W    = SUM_BITS + KEY_BITS + 1;

   logic             cmd_push, cmd_full, cmd_pop, cmd_empty;
   logic [CMD_W-1:0] cmd_in_data, cmd_out_data;
   logic             clearing;

   rpgbs_parse #(
      .KEY_SLOTS (KEY_SLOTS),
      .SUM_BITS  (SUM_BITS)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .hold      (clearing),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_in_data)
   );

   rpgbs_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (rpgbs_pkg::CMD_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_data),
      .empty     (cmd_empty)
   );

   rpgbs_table #(
      .KEY_SLOTS (KEY_SLOTS),
      .SUM_BITS  (SUM_BITS)
   ) u_table (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_out_data),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/rpgbs_parse.sv =====
// Front end: record framing parser that turns input items into table commands.
`timescale 1ns / 1ps
`default_nettype none

module rpgbs_parse #(
   parameter int KEY_SLOTS = 1024,
   parameter int SUM_BITS  = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire rpgbs_pkg::req_type  req_data,
   input  wire logic                hold,
   input  wire logic                cmd_full,
   output logic                     cmd_push,
   output logic [SUM_BITS+$clog2(KEY_SLOTS):0] cmd_data
);

   localparam int KEY_BITS = $clog2(KEY_SLOTS);
   localparam int ACC_BITS = $clog2(KEY_SLOTS + 1);
   localparam int KW       = ACC_BITS + 4;
   localparam int VW       = SUM_BITS + 4;

   localparam logic [2:0] MODE_WAIT  = 3'd0;
   localparam logic [2:0] MODE_HEAD  = 3'd1;
   localparam logic [2:0] MODE_KEY   = 3'd2;
   localparam logic [2:0] MODE_COLON = 3'd3;
   localparam logic [2:0] MODE_SPACE = 3'd4;
   localparam logic [2:0] MODE_VALUE = 3'd5;

   logic [2:0]          mode_ff, mode_in;
   logic [3:0]          skip_ff, skip_in;
   logic [ACC_BITS-1:0] key_ff, key_in;
   logic [SUM_BITS-1:0] value_ff, value_in;

   logic          accept;
   logic [7:0]    b;
   logic [3:0]    digit;
   logic [3:0]    skip_dec;
   logic [KW-1:0] key_wide;
   logic [VW-1:0] value_wide;
   logic          commit;

   assign req_ready = !hold && !cmd_full;
   assign accept    = req_valid && req_ready;
   assign b         = req_data.data_byte;

   // non-digit bytes count as zero
   assign digit = (b >= rpgbs_pkg::CH_ZERO && b <= rpgbs_pkg::CH_NINE) ?
                  4'(b - rpgbs_pkg::CH_ZERO) : 4'd0;
   assign skip_dec   = (skip_ff != 4'd0) ? skip_ff - 4'd1 : 4'd0;
   assign key_wide   = (KW'(key_ff) << 3) + (KW'(key_ff) << 1) + KW'(digit);
   assign value_wide = (VW'(value_ff) << 3) + (VW'(value_ff) << 1) + VW'(digit);

   assign commit = (mode_ff == MODE_VALUE) && (b == rpgbs_pkg::CH_RBRACE) &&
                   (key_ff < ACC_BITS'(KEY_SLOTS));

   assign cmd_push = accept &&
                     ((req_data.operation == rpgbs_pkg::OP_REPORT) || commit);
   assign cmd_data = {(req_data.operation == rpgbs_pkg::OP_REPORT),
                      key_ff[KEY_BITS-1:0], value_ff};

   always_comb begin
      mode_in  = mode_ff;
      skip_in  = skip_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (accept && req_data.operation == rpgbs_pkg::OP_BYTE) begin
         unique case (mode_ff)
            MODE_WAIT: begin
               if (b == rpgbs_pkg::CH_LBRACE) begin
                  mode_in = MODE_HEAD;
                  skip_in = rpgbs_pkg::HEAD_SKIP;
               end
            end
            MODE_HEAD: begin
               skip_in = skip_dec;
               if (skip_dec == 4'd0) begin
                  mode_in = MODE_KEY;
                  key_in  = '0;
               end
            end
            MODE_KEY: begin
               if (b == rpgbs_pkg::CH_QUOTE) begin
                  mode_in = MODE_COLON;
               end else if (key_wide >= KW'(KEY_SLOTS)) begin
                  key_in = ACC_BITS'(KEY_SLOTS);
               end else begin
                  key_in = key_wide[ACC_BITS-1:0];
               end
            end
            MODE_COLON: begin
               if (b == rpgbs_pkg::CH_COLON) mode_in = MODE_SPACE;
            end
            MODE_SPACE: begin
               mode_in  = MODE_VALUE;
               value_in = '0;
            end
            MODE_VALUE: begin
               if (b == rpgbs_pkg::CH_RBRACE) begin
                  mode_in = MODE_WAIT;
               end else if (value_wide[VW-1:SUM_BITS] != 4'd0) begin
                  value_in = '1;
               end else begin
                  value_in = value_wide[SUM_BITS-1:0];
               end
            end
            default: begin
               mode_in = MODE_WAIT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_WAIT;
         skip_ff  <= '0;
         key_ff   <= '0;
         value_ff <= '0;
      end else begin
         mode_ff  <= mode_in;
         skip_ff  <= skip_in;
         key_ff   <= key_in;
         value_ff <= value_in;
      end
   end

endmodule

`default_nettype wire

// ===== design/rpgbs_fifo.sv =====
// Small command queue between the parser and the table engine.
`timescale 1ns / 1ps
`default_nettype none

module rpgbs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = store[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) store[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         if (do_pop) rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         if (do_push && !do_pop) count_ff <= count_ff + CNT_W'(1);
         else if (do_pop && !do_push) count_ff <= count_ff - CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

// ===== design/rpgbs_share.sv =====
// Bit-serial divider for the Q1.16 share of a key sum in the grand total.
`timescale 1ns / 1ps
`default_nettype none

module rpgbs_share #(
   parameter int SUM_BITS = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [SUM_BITS-1:0] sum,
   input  wire logic [SUM_BITS-1:0] total,
   output logic                     done,
   output logic [rpgbs_pkg::SHARE_W-1:0] share
);

   localparam int FRAC  = rpgbs_pkg::SHARE_FRAC;
   localparam int SW    = rpgbs_pkg::SHARE_W;
   localparam int CNT_W = $clog2(FRAC + 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SUM_BITS-1:0] rem_ff, rem_in;
   logic [SUM_BITS-1:0] total_ff, total_in;
   logic [FRAC-1:0]     quo_ff, quo_in;
   logic [SW-1:0]       share_ff, share_in;

   logic [SUM_BITS:0] twice, diff;
   logic              take;

   assign twice = {rem_ff, 1'b0};
   assign take  = (twice >= {1'b0, total_ff});
   assign diff  = twice - {1'b0, total_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      total_in = total_ff;
      quo_in   = quo_ff;
      share_in = share_ff;
      if (start) begin
         if (total == '0) begin
            share_in = '0;
            done_in  = 1'b1;
            busy_in  = 1'b0;
         end else if (sum >= total) begin
            share_in = rpgbs_pkg::SHARE_WHOLE;
            done_in  = 1'b1;
            busy_in  = 1'b0;
         end else begin
            rem_in   = sum;
            total_in = total;
            quo_in   = '0;
            count_in = CNT_W'(FRAC);
            busy_in  = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in   = take ? diff[SUM_BITS-1:0] : twice[SUM_BITS-1:0];
         quo_in   = {quo_ff[FRAC-2:0], take};
         count_in = count_ff - CNT_W'(1);
         if (count_ff == CNT_W'(1)) begin
            busy_in  = 1'b0;
            done_in  = 1'b1;
            share_in = SW'({quo_ff[FRAC-2:0], take});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      total_ff <= total_in;
      quo_ff   <= quo_in;
      share_ff <= share_in;
   end

   assign done  = done_ff;
   assign share = share_ff;

endmodule

`default_nettype wire

// ===== design/rpgbs_table.sv =====
// Back end: sum table memory, grand total, report scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module rpgbs_table #(
   parameter int KEY_SLOTS = 1024,
   parameter int SUM_BITS  = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                cmd_empty,
   output logic                     cmd_pop,
   input  wire logic [SUM_BITS+$clog2(KEY_SLOTS):0] cmd_data,
   output logic                     clearing,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output rpgbs_pkg::rsp_type       rsp_data
);

   localparam int KEY_BITS  = $clog2(KEY_SLOTS);
   localparam int ACC_BITS  = $clog2(KEY_SLOTS + 1);
   localparam int CMD_W     = SUM_BITS + KEY_BITS + 1;
   localparam int OUT_KEY_W = rpgbs_pkg::KEY_W;
   localparam int OUT_SUM_W = rpgbs_pkg::KEY_SUM_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_SCAN  = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   logic [SUM_BITS-1:0] mem [KEY_SLOTS];

   logic [2:0]          state_ff, state_in;
   logic [KEY_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic [KEY_BITS-1:0] add_key_ff, add_key_in;
   logic [SUM_BITS-1:0] add_val_ff, add_val_in;
   logic [ACC_BITS-1:0] scan_addr_ff, scan_addr_in;
   logic                pend_ff, pend_in;
   logic [KEY_BITS-1:0] chk_addr_ff, chk_addr_in;
   logic [ACC_BITS-1:0] cursor_ff, cursor_in;
   logic [SUM_BITS-1:0] total_ff, total_in;
   logic [KEY_BITS-1:0] found_key_ff, found_key_in;
   logic [SUM_BITS-1:0] found_sum_ff, found_sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rpgbs_pkg::rsp_type  rsp_data_ff, rsp_data_in;
   logic [SUM_BITS-1:0] rdata_ff;

   logic                wr_en, rd_en;
   logic [KEY_BITS-1:0] wr_addr, rd_addr;
   logic [SUM_BITS-1:0] wr_data;

   logic                cmd_is_report;
   logic [KEY_BITS-1:0] cmd_key;
   logic [SUM_BITS-1:0] cmd_value;

   logic                div_start, div_done;
   logic [rpgbs_pkg::SHARE_W-1:0] div_share;

   function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                   input logic [SUM_BITS-1:0] c);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, c};
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

   assign cmd_is_report = cmd_data[CMD_W-1];
   assign cmd_key       = cmd_data[SUM_BITS +: KEY_BITS];
   assign cmd_value     = cmd_data[SUM_BITS-1:0];

   assign clearing  = (state_ff == ST_CLEAR);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      add_key_in   = add_key_ff;
      add_val_in   = add_val_ff;
      scan_addr_in = scan_addr_ff;
      pend_in      = pend_ff;
      chk_addr_in  = chk_addr_ff;
      cursor_in    = cursor_ff;
      total_in     = total_ff;
      found_key_in = found_key_ff;
      found_sum_in = found_sum_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = clr_addr_ff;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = cmd_key;
      cmd_pop      = 1'b0;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            clr_addr_in = clr_addr_ff + KEY_BITS'(1);
            if (clr_addr_ff == KEY_BITS'(KEY_SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (!cmd_empty) begin
               if (!cmd_is_report) begin
                  cmd_pop    = 1'b1;
                  rd_en      = 1'b1;
                  add_key_in = cmd_key;
                  add_val_in = cmd_value;
                  state_in   = ST_ADD;
               end else if (!rsp_valid_ff) begin
                  cmd_pop      = 1'b1;
                  scan_addr_in = cursor_ff;
                  pend_in      = 1'b0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_ADD: begin
            wr_en    = 1'b1;
            wr_addr  = add_key_ff;
            wr_data  = sat_add(rdata_ff, add_val_ff);
            total_in = sat_add(total_ff, add_val_ff);
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // one slot read per cycle, checked the cycle after
            if (pend_ff && rdata_ff != '0) begin
               found_key_in = chk_addr_ff;
               found_sum_in = rdata_ff;
               cursor_in    = ACC_BITS'(chk_addr_ff) + ACC_BITS'(1);
               div_start    = 1'b1;
               state_in     = ST_DIV;
            end else if (scan_addr_ff == ACC_BITS'(KEY_SLOTS)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               cursor_in    = '0;
               state_in     = ST_IDLE;
            end else begin
               rd_en        = 1'b1;
               rd_addr      = scan_addr_ff[KEY_BITS-1:0];
               chk_addr_in  = scan_addr_ff[KEY_BITS-1:0];
               pend_in      = 1'b1;
               scan_addr_in = scan_addr_ff + ACC_BITS'(1);
            end
         end
         ST_DIV: begin
            if (div_done) begin
               rsp_valid_in        = 1'b1;
               rsp_data_in.found   = 1'b1;
               rsp_data_in.key     = OUT_KEY_W'(found_key_ff);
               rsp_data_in.key_sum = OUT_SUM_W'(found_sum_ff);
               rsp_data_in.share   = div_share;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rdata_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         pend_ff      <= 1'b0;
         cursor_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         pend_ff      <= pend_in;
         cursor_ff    <= cursor_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      add_key_ff   <= add_key_in;
      add_val_ff   <= add_val_in;
      scan_addr_ff <= scan_addr_in;
      chk_addr_ff  <= chk_addr_in;
      found_key_ff <= found_key_in;
      found_sum_ff <= found_sum_in;
      rsp_data_ff  <= rsp_data_in;
   end

   rpgbs_share #(
      .SUM_BITS (SUM_BITS)
   ) u_share (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .sum   (rdata_ff),
      .total (total_ff),
      .done  (div_done),
      .share (div_share)
   );

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> !cmd_pop)
      else $error("command taken during table clear");

   a_report_needs_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd_pop && cmd_is_report |-> !rsp_valid_ff)
      else $error("report started while a result is pending");

   a_not_found_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.found |->
      rsp_data_ff.key == '0 && rsp_data_ff.key_sum == '0 && rsp_data_ff.share == '0)
      else $error("end-of-table result carries data");

   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= ACC_BITS'(KEY_SLOTS))
      else $error("report cursor beyond table");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("share result outside divide state");

endmodule

`default_nettype wire
